>>> sv/dalt_pkg.sv
`timescale 1ns / 1ps

package dalt_pkg;

	localparam int PULSE_W    = 15;
	localparam int DEADBAND_W = 12;
	localparam int STEP_W     = 12;
	localparam int CMD_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = PULSE_W;

	localparam int SAMPLE_BITS_DEF = 12;

	localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_AUTO  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_UP    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DOWN  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MANUAL_STEP = 2'd3;

	localparam logic [PULSE_W-1:0]    MIN_PULSE_RST   = 15'd600;
	localparam logic [PULSE_W-1:0]    MAX_PULSE_RST   = 15'd2100;
	localparam logic [DEADBAND_W-1:0] DEADBAND_RST    = 12'd30;
	localparam logic [STEP_W-1:0]     MANUAL_STEP_RST = 12'd150;
	localparam logic [PULSE_W-1:0]    POSITION_RST    = 15'd1500;

	localparam int OUT_DATA_W = ((2 * PULSE_W + 7) / 8) * 8;

endpackage

>>> sv/dual_axis_light_tracker_unit.sv
`timescale 1ns / 1ps

// Two-axis light tracker. Each input item carries a command and four light
// samples; each item yields exactly one result item holding the tilt and pan
// servo compare values after that item. One item is accepted per clock while
// the output is not stalled. An item is held in the input register, where its
// position update is computed, and is then loaded into the two position
// registers, which set the pace and drive the output directly; they only
// change when a result is loaded. Write configuration only while idle.
module dual_axis_light_tracker_unit #(
	parameter int SAMPLE_BITS = dalt_pkg::SAMPLE_BITS_DEF,
	parameter int IN_DATA_W   = ((dalt_pkg::CMD_W + 4 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// cmd, sense_top_left, sense_top_right, sense_bottom_left, sense_bottom_right
	input  logic [IN_DATA_W-1:0]                s_axis_tdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tilt_pulse, pan_pulse
	output logic [dalt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic                                cfg_wr_en,
	input  logic [dalt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dalt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int PW = dalt_pkg::PULSE_W;
	localparam int SB = SAMPLE_BITS;
	localparam int AW = PW + 2;
	localparam logic signed [AW-1:0] ONE_W = AW'(1);

	logic [PW-1:0]                  min_pulse_q;
	logic [PW-1:0]                  max_pulse_q;
	logic [dalt_pkg::DEADBAND_W-1:0] deadband_q;
	logic [dalt_pkg::STEP_W-1:0]     manual_step_q;

	logic                      in_valid_s1;
	logic [dalt_pkg::CMD_W-1:0] cmd_s1;
	logic [SB-1:0]             tl_s1, tr_s1, bl_s1, br_s1;

	logic          out_valid_q;
	logic [PW-1:0] tilt_q, pan_q;
	logic          advance;

	logic [SB:0]   sum_top, sum_bot, sum_left, sum_right;
	logic [SB-1:0] avg_top, avg_bot, avg_left, avg_right;
	logic          tilt_up, tilt_dn, pan_up, pan_dn;
	logic [PW-1:0] tilt_auto, pan_auto, tilt_lower, tilt_higher, pan_lower, pan_higher;
	logic [PW-1:0] tilt_nxt, pan_nxt;

	function automatic logic exceeds(input logic [SB-1:0] hi, input logic [SB-1:0] lo,
			input logic [dalt_pkg::DEADBAND_W-1:0] db);
		logic [AW-1:0] d;
		d = AW'(hi) - AW'(lo);
		return (hi > lo) && (d > AW'(db));
	endfunction

	function automatic logic [PW-1:0] auto_axis(input logic [PW-1:0] pos, input logic up,
			input logic dn, input logic [PW-1:0] minp, input logic [PW-1:0] maxp);
		logic signed [AW-1:0] r;
		r = signed'({2'b00, pos});
		if (up) begin
			r = r + ONE_W;
			if (r > signed'({2'b00, maxp}))
				r = signed'({2'b00, maxp});
		end else if (dn) begin
			r = r - ONE_W;
			if (r < signed'({2'b00, minp}))
				r = signed'({2'b00, minp});
		end
		return r[PW-1:0];
	endfunction

	function automatic logic [PW-1:0] move_lower(input logic [PW-1:0] pos,
			input logic [dalt_pkg::STEP_W-1:0] step, input logic [PW-1:0] minp);
		logic signed [AW-1:0] r;
		r = signed'({2'b00, pos}) - signed'(AW'(step));
		if (pos <= minp)
			return pos;
		if (r < signed'({2'b00, minp}))
			return minp;
		return r[PW-1:0];
	endfunction

	function automatic logic [PW-1:0] move_higher(input logic [PW-1:0] pos,
			input logic [dalt_pkg::STEP_W-1:0] step, input logic [PW-1:0] maxp);
		logic signed [AW-1:0] r;
		r = signed'({2'b00, pos}) + signed'(AW'(step));
		if (pos >= maxp)
			return pos;
		if (r > signed'({2'b00, maxp}))
			return maxp;
		return r[PW-1:0];
	endfunction

	assign advance       = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(dalt_pkg::OUT_DATA_W - 2 * PW){1'b0}}, pan_q, tilt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q   <= dalt_pkg::MIN_PULSE_RST;
			max_pulse_q   <= dalt_pkg::MAX_PULSE_RST;
			deadband_q    <= dalt_pkg::DEADBAND_RST;
			manual_step_q <= dalt_pkg::MANUAL_STEP_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				dalt_pkg::REG_MIN_PULSE:   min_pulse_q   <= cfg_wdata;
				dalt_pkg::REG_MAX_PULSE:   max_pulse_q   <= cfg_wdata;
				dalt_pkg::REG_DEADBAND:    deadband_q    <= cfg_wdata[dalt_pkg::DEADBAND_W-1:0];
				dalt_pkg::REG_MANUAL_STEP: manual_step_q <= cfg_wdata[dalt_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1 <= s_axis_tdata[dalt_pkg::CMD_W-1:0];
			tl_s1  <= s_axis_tdata[dalt_pkg::CMD_W + 0*SB +: SB];
			tr_s1  <= s_axis_tdata[dalt_pkg::CMD_W + 1*SB +: SB];
			bl_s1  <= s_axis_tdata[dalt_pkg::CMD_W + 2*SB +: SB];
			br_s1  <= s_axis_tdata[dalt_pkg::CMD_W + 3*SB +: SB];
		end
	end

	always_comb begin
		sum_top   = {1'b0, tl_s1} + {1'b0, tr_s1};
		sum_bot   = {1'b0, bl_s1} + {1'b0, br_s1};
		sum_left  = {1'b0, tl_s1} + {1'b0, bl_s1};
		sum_right = {1'b0, tr_s1} + {1'b0, br_s1};
		avg_top   = sum_top[SB:1];
		avg_bot   = sum_bot[SB:1];
		avg_left  = sum_left[SB:1];
		avg_right = sum_right[SB:1];

		tilt_up = exceeds(avg_top, avg_bot, deadband_q);
		tilt_dn = exceeds(avg_bot, avg_top, deadband_q);
		pan_up  = exceeds(avg_left, avg_right, deadband_q);
		pan_dn  = exceeds(avg_right, avg_left, deadband_q);

		tilt_auto   = auto_axis(tilt_q, tilt_up, tilt_dn, min_pulse_q, max_pulse_q);
		pan_auto    = auto_axis(pan_q, pan_up, pan_dn, min_pulse_q, max_pulse_q);
		tilt_lower  = move_lower(tilt_q, manual_step_q, min_pulse_q);
		tilt_higher = move_higher(tilt_q, manual_step_q, max_pulse_q);
		pan_lower   = move_lower(pan_q, manual_step_q, min_pulse_q);
		pan_higher  = move_higher(pan_q, manual_step_q, max_pulse_q);

		tilt_nxt = tilt_q;
		pan_nxt  = pan_q;
		case (cmd_s1)
			dalt_pkg::CMD_AUTO: begin
				tilt_nxt = tilt_auto;
				pan_nxt  = pan_auto;
			end
			dalt_pkg::CMD_UP:    tilt_nxt = tilt_lower;
			dalt_pkg::CMD_DOWN:  tilt_nxt = tilt_higher;
			dalt_pkg::CMD_LEFT:  pan_nxt  = pan_higher;
			dalt_pkg::CMD_RIGHT: pan_nxt  = pan_lower;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			tilt_q      <= dalt_pkg::POSITION_RST;
			pan_q       <= dalt_pkg::POSITION_RST;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				tilt_q      <= tilt_nxt;
				pan_q       <= pan_nxt;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_stall_keeps_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(tilt_q) && $stable(pan_q))
		else $error("positions changed without a result load");

	a_held_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && !advance |=> in_valid_s1 && $stable(cmd_s1))
		else $error("pending item lost from input register");

	a_none_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (cmd_s1 == dalt_pkg::CMD_NONE) |=> $stable(tilt_q) && $stable(pan_q))
		else $error("idle command moved a position");

	a_up_not_raise: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (cmd_s1 == dalt_pkg::CMD_UP) |=> tilt_q <= $past(tilt_q) && $stable(pan_q))
		else $error("up command raised tilt or moved pan");

	a_left_not_lower: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (cmd_s1 == dalt_pkg::CMD_LEFT) |=> pan_q >= $past(pan_q) && $stable(tilt_q))
		else $error("left command lowered pan or moved tilt");
`endif

endmodule

>>> tb/dual_axis_light_tracker_unit_tb.sv
`timescale 1ns / 1ps

module dual_axis_light_tracker_unit_tb;

	localparam int CW = dalt_pkg::CMD_W;
	localparam int PW = dalt_pkg::PULSE_W;
	localparam int CDW = dalt_pkg::CFG_DATA_W;
	localparam int SW = dalt_pkg::SAMPLE_BITS_DEF;
	localparam int IN_W = ((CW + 4 * SW + 7) / 8) * 8;
	localparam int OUT_W = dalt_pkg::OUT_DATA_W;
	localparam int SMAX = (1 << SW) - 1;
	localparam int IDLE_LIMIT = 1000;
	localparam logic [CW-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [CW-1:0] CMD_SPARE7 = 3'd7;

	typedef struct packed {
		logic [PW-1:0] tilt;
		logic [PW-1:0] pan;
	} pulse_pair_t;

	class tracker_scoreboard;
		int min_pulse, max_pulse, deadband, manual_step;
		int tilt_pos, pan_pos;
		pulse_pair_t pulse_q[$];
		int unsigned errors, items, results;

		function new();
			min_pulse = int'(dalt_pkg::MIN_PULSE_RST);
			max_pulse = int'(dalt_pkg::MAX_PULSE_RST);
			deadband = int'(dalt_pkg::DEADBAND_RST);
			manual_step = int'(dalt_pkg::MANUAL_STEP_RST);
			tilt_pos = int'(dalt_pkg::POSITION_RST);
			pan_pos = int'(dalt_pkg::POSITION_RST);
		endfunction

		function void set_reg(logic [dalt_pkg::CFG_IDX_W-1:0] idx, int value);
			case (idx)
				dalt_pkg::REG_MIN_PULSE: min_pulse = value & 'h7fff;
				dalt_pkg::REG_MAX_PULSE: max_pulse = value & 'h7fff;
				dalt_pkg::REG_DEADBAND: deadband = value & 'hfff;
				dalt_pkg::REG_MANUAL_STEP: manual_step = value & 'hfff;
				default: ;
			endcase
		endfunction

		// one count toward the brighter side once the gap beats the deadband
		function int nudge(int pos, int brighter, int dimmer);
			int diff;
			diff = brighter - dimmer;
			if (diff > deadband || diff < -deadband) begin
				if (diff > 0) begin
					pos = pos + 1;
					if (pos > max_pulse)
						pos = max_pulse;
				end else begin
					pos = pos - 1;
					if (pos < min_pulse)
						pos = min_pulse;
				end
			end
			return pos;
		endfunction

		function int step_down(int pos);
			if (pos > min_pulse)
				pos = (pos - manual_step < min_pulse) ? min_pulse : pos - manual_step;
			return pos;
		endfunction

		function int step_up(int pos);
			if (pos < max_pulse)
				pos = (pos + manual_step > max_pulse) ? max_pulse : pos + manual_step;
			return pos;
		endfunction

		function void note_item(logic [IN_W-1:0] data);
			logic [CW-1:0] cmd;
			int tl, tr, bl, br;
			pulse_pair_t exp_p;
			cmd = data[CW-1:0];
			tl = int'(data[CW +: SW]);
			tr = int'(data[CW + SW +: SW]);
			bl = int'(data[CW + 2 * SW +: SW]);
			br = int'(data[CW + 3 * SW +: SW]);
			case (cmd)
				dalt_pkg::CMD_AUTO: begin
					tilt_pos = nudge(tilt_pos, (tl + tr) >>> 1, (bl + br) >>> 1);
					pan_pos = nudge(pan_pos, (tl + bl) >>> 1, (tr + br) >>> 1);
				end
				dalt_pkg::CMD_UP: tilt_pos = step_down(tilt_pos);
				dalt_pkg::CMD_DOWN: tilt_pos = step_up(tilt_pos);
				dalt_pkg::CMD_LEFT: pan_pos = step_up(pan_pos);
				dalt_pkg::CMD_RIGHT: pan_pos = step_down(pan_pos);
				default: ;
			endcase
			exp_p.tilt = tilt_pos[PW-1:0];
			exp_p.pan = pan_pos[PW-1:0];
			pulse_q.push_back(exp_p);
			items++;
		endfunction

		function void report(string what, int exp_v, int act_v);
			errors++;
			if (errors <= 10)
				$display("mismatch on %s: expected %0d, got %0d", what, exp_v, act_v);
		endfunction

		function void check_result(logic [OUT_W-1:0] data);
			pulse_pair_t exp_p;
			logic [PW-1:0] tilt, pan;
			tilt = data[PW-1:0];
			pan = data[2 * PW - 1:PW];
			results++;
			if (pulse_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result with nothing pending: tilt %0d pan %0d", tilt, pan);
				return;
			end
			exp_p = pulse_q.pop_front();
			if (tilt !== exp_p.tilt)
				report("tilt_pulse", int'(exp_p.tilt), int'(tilt));
			if (pan !== exp_p.pan)
				report("pan_pulse", int'(exp_p.pan), int'(pan));
		endfunction

		function int pending();
			return pulse_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic [IN_W-1:0] s_axis_tdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic cfg_wr_en;
	logic [dalt_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [CDW-1:0] cfg_wdata;

	tracker_scoreboard sb = new();
	bit burst;
	int settings;
	int idle_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	dual_axis_light_tracker_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_item(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
				$display("FAIL dual_axis_light_tracker_unit");
				$finish;
			end
		end
	end

	// result side
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	task automatic send_item(logic [CW-1:0] cmd, int tl, int tr, int bl, int br);
		int gap;
		logic [IN_W-1:0] word;
		gap = burst ? 0 : $urandom_range(0, 4);
		word = '0;
		word[CW + 4 * SW - 1:0] = {SW'(br), SW'(bl), SW'(tr), SW'(tl), cmd};
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= word;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_random();
		logic [CW-1:0] cmd;
		int s [4];
		int pick, base, spread, v;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			cmd = dalt_pkg::CMD_AUTO;
		else if (pick < 8)
			cmd = CW'($urandom_range(dalt_pkg::CMD_UP, dalt_pkg::CMD_RIGHT));
		else begin
			case ($urandom_range(0, 2))
				0: cmd = dalt_pkg::CMD_NONE;
				1: cmd = CMD_SPARE6;
				default: cmd = CMD_SPARE7;
			endcase
		end
		// near-threshold samples cluster around a base within twice the deadband plus three
		base = $urandom_range(0, SMAX);
		spread = sb.deadband * 2 + 3;
		pick = $urandom_range(0, 2);
		foreach (s[k]) begin
			case (pick)
				0: s[k] = int'($urandom_range(0, SMAX));
				1: begin
					v = base + int'($urandom_range(0, 2 * spread)) - spread;
					if (v < 0)
						v = 0;
					if (v > SMAX)
						v = SMAX;
					s[k] = v;
				end
				default: s[k] = $urandom_range(0, 1) ? SMAX : 0;
			endcase
		end
		send_item(cmd, s[0], s[1], s[2], s[3]);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [dalt_pkg::CFG_IDX_W-1:0] idx, int value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CDW'(value);
		@(posedge clk);
		sb.set_reg(idx, value);
	endtask

	task automatic set_config(int min_p, int max_p, int db, int step);
		drain();
		write_reg(dalt_pkg::REG_MIN_PULSE, min_p);
		write_reg(dalt_pkg::REG_MAX_PULSE, max_p);
		write_reg(dalt_pkg::REG_DEADBAND, db);
		write_reg(dalt_pkg::REG_MANUAL_STEP, step);
		cfg_wr_en <= 1'b0;
		settings++;
	endtask

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) begin
			burst = ((i / 30) % 4) == 2;
			if (i == n / 2)
				drain();
			send_random();
		end
		burst = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		burst = 1'b0;
		settings = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// unused commands, auto in each direction, deadband edge, truncation, manual steps
		send_item(dalt_pkg::CMD_NONE, 0, 0, 0, 0);
		send_item(CMD_SPARE6, SMAX, SMAX, SMAX, SMAX);
		send_item(CMD_SPARE7, 'haaa, 'h555, 'haaa, 'h555);
		send_item(dalt_pkg::CMD_AUTO, SMAX, SMAX, 0, 0);
		send_item(dalt_pkg::CMD_AUTO, 0, 0, SMAX, SMAX);
		send_item(dalt_pkg::CMD_AUTO, SMAX, 0, SMAX, 0);
		send_item(dalt_pkg::CMD_AUTO, 0, SMAX, 0, SMAX);
		send_item(dalt_pkg::CMD_AUTO, SMAX, SMAX, SMAX, SMAX);
		send_item(dalt_pkg::CMD_AUTO, 130, 130, 100, 100);
		send_item(dalt_pkg::CMD_AUTO, 131, 131, 100, 100);
		send_item(dalt_pkg::CMD_AUTO, 100, 100, 131, 131);
		send_item(dalt_pkg::CMD_AUTO, 0, 1, 0, 0);
		repeat (5) send_item(dalt_pkg::CMD_DOWN, int'($urandom_range(0, SMAX)),
			int'($urandom_range(0, SMAX)), int'($urandom_range(0, SMAX)), 0);
		repeat (2) send_item(dalt_pkg::CMD_UP, 0, 0, 0, 0);
		repeat (2) send_item(dalt_pkg::CMD_LEFT, 0, 0, 0, 0);
		repeat (2) send_item(dalt_pkg::CMD_RIGHT, 0, 0, 0, 0);

		run_random(110);
		set_config(0, 20000, 0, 4095);
		run_random(110);
		set_config(20000, 0, 4095, 0);
		run_random(110);
		set_config(1400, 1600, 5, 37);
		run_random(110);
		set_config(1500, 1500, 0, 1);
		run_random(110);
		repeat (2) begin
			set_config(int'($urandom_range(0, 20000)), int'($urandom_range(0, 20000)),
				int'($urandom_range(0, 63)), int'($urandom_range(0, 4095)));
			run_random(110);
		end

		drain();
		repeat (6) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0d results never arrived", sb.pending());
		$display("Sent %0d items under %0d register settings, %0d results checked, %0d mismatches",
			sb.items, settings, sb.results, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS dual_axis_light_tracker_unit");
		else
			$display("FAIL dual_axis_light_tracker_unit");
		$finish;
	end

endmodule

>>> dual_axis_light_tracker_unit.f
sv/dalt_pkg.sv
sv/dual_axis_light_tracker_unit.sv
tb/dual_axis_light_tracker_unit_tb.sv
